// ----- rtl/srl_pkg.sv -----
// ---------------------------------------------------------------------------
// srl_pkg
// Shared types, codes and the name cleaning function for the sorted record
// list unit.
// ---------------------------------------------------------------------------
package srl_pkg;

   localparam int NAME_W  = 64;
   localparam int VOL_W   = 32;
   localparam int PRICE_W = 32;
   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int CNT_W   = 6;
   localparam int REQ_W   = 136;
   localparam int RSP_W   = 144;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CMP,
      ST_INS_NEW,
      ST_RM_CMP,
      ST_RD_DATA,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [NAME_W-1:0]        name;
      logic signed [VOL_W-1:0]  volume;
      logic [PRICE_W-1:0]       price;
   } rec_type;

   typedef struct packed {
      logic not_after;
      logic name_eq;
   } cmp_type;

   typedef struct packed {
      logic    ok;
      rec_type rec;
   } res_type;

   // keep the first chars bytes up to the first NUL, optionally fold A-Z
   function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] key,
                                                   input logic fold,
                                                   input int chars);
      logic [NAME_W-1:0] res;
      logic              ended;
      logic [7:0]        b;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < 8; i++) begin
         b = key[NAME_W-1-8*i -: 8];
         if (i >= chars || b == 8'h00) begin
            ended = 1'b1;
         end
         if (ended) begin
            b = 8'h00;
         end
         if (fold && b >= 8'h41 && b <= 8'h5a) begin
            b = b + 8'h20;
         end
         res[NAME_W-1-8*i -: 8] = b;
      end
      return res;
   endfunction

endpackage

// ----- rtl/srl_mem.sv -----
// ---------------------------------------------------------------------------
// srl_mem
// Record store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module srl_mem
   import srl_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rec_type       wr_data,
   input  logic [AW-1:0] rd_addr,
   output rec_type       rd_data
);

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/srl_cmp.sv -----
// ---------------------------------------------------------------------------
// srl_cmp
// Shared key comparator: name, then signed volume.
// ---------------------------------------------------------------------------
module srl_cmp
   import srl_pkg::*;
(
   input  rec_type rec,
   input  rec_type key,
   output cmp_type res
);

   logic name_lt;

   assign name_lt       = rec.name < key.name;
   assign res.name_eq   = rec.name == key.name;
   assign res.not_after = name_lt || (res.name_eq && (rec.volume <= key.volume));

endmodule

// ----- rtl/sorted_record_list_unit.sv -----
// Operation: an insert scans from the end of the list and shifts records up, a
// remove scans from the start and shifts later records down, a read fetches one
// position; the scan-and-shift loop runs through the record store, one read and
// at most one write a cycle, with one compare unit.
// Throughput: one word at a time; req_tready is high only while idle.
// Reset: synchronous; the list empties, stored records are left as they are.
// ---------------------------------------------------------------------------
// sorted_record_list_unit
// Sorted record list with insert, remove by name and read by position.
// ---------------------------------------------------------------------------
module sorted_record_list_unit
   import srl_pkg::*;
#(
   parameter int CAPACITY   = 32,
   parameter int NAME_CHARS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // operation, name_key, volume, price_bits, position
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // ok, out_name, out_volume, out_price_bits, entry_count, is_empty, is_full
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   rec_type       key_ff, key_in;
   res_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   op_type            req_op;
   logic [NAME_W-1:0] req_name;
   logic [VOL_W-1:0]  req_vol;
   logic [PRICE_W-1:0] req_price;
   logic [POS_W-1:0]  req_pos;
   logic [PW-1:0]     pos_ext;
   logic              pos_ok;

   assign req_op    = op_type'(req_tdata[1:0]);
   assign req_name  = req_tdata[65:2];
   assign req_vol   = req_tdata[97:66];
   assign req_price = req_tdata[129:98];
   assign req_pos   = req_tdata[135:130];
   assign pos_ext   = PW'(req_pos);
   assign pos_ok    = (req_pos != '0) && (pos_ext <= PW'(count_ff));

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   rec_type       wr_data;
   logic [AW-1:0] rd_addr;
   rec_type       rd_data;
   cmp_type       cmp;
   logic [CW-1:0] idx_inc;

   srl_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   srl_cmp u_cmp (
      .rec (rd_data),
      .key (key_ff),
      .res (cmp)
   );

   assign idx_inc = idx_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = key_ff;
      rd_addr      = '0;
      req_tready   = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               res_in      = '0;
               key_in.volume = req_vol;
               key_in.price  = req_price;
               found_in    = 1'b0;
               case (req_op)
                  OP_INSERT: begin
                     key_in.name = clean_name(req_name, 1'b1, NAME_CHARS);
                     idx_in      = count_ff;
                     rd_addr     = AW'(count_ff - CW'(1));
                     if (count_ff == CW'(CAPACITY)) begin
                        state_in = ST_OUT;
                     end else if (count_ff == '0) begin
                        state_in = ST_INS_NEW;
                     end else begin
                        state_in = ST_INS_CMP;
                     end
                  end
                  OP_REMOVE: begin
                     key_in.name = clean_name(req_name, 1'b0, NAME_CHARS);
                     idx_in      = '0;
                     rd_addr     = '0;
                     state_in    = ST_RM_CMP;
                  end
                  OP_READ: begin
                     rd_addr = AW'(pos_ext - PW'(1));
                     if (pos_ok) begin
                        state_in = ST_RD_DATA;
                     end else begin
                        res_in.rec.volume = '1;
                        state_in          = ST_OUT;
                     end
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end

         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (cmp.not_after) begin
               wr_data   = key_ff;
               count_in  = count_ff + CW'(1);
               res_in.ok = 1'b1;
               state_in  = ST_OUT;
            end else begin
               wr_data = rd_data;
               idx_in  = idx_ff - CW'(1);
               rd_addr = AW'(idx_ff - CW'(2));
               if (idx_ff == CW'(1)) begin
                  state_in = ST_INS_NEW;
               end
            end
         end

         ST_INS_NEW: begin
            wr_en     = 1'b1;
            wr_data   = key_ff;
            count_in  = count_ff + CW'(1);
            res_in.ok = 1'b1;
            state_in  = ST_OUT;
         end

         ST_RM_CMP: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  count_in  = count_ff - CW'(1);
                  res_in.ok = 1'b1;
               end
               state_in = ST_OUT;
            end else begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(idx_ff - CW'(1));
                  wr_data = rd_data;
               end else if (cmp.name_eq) begin
                  found_in = 1'b1;
               end
               idx_in  = idx_inc;
               rd_addr = (idx_inc < CW'(CAPACITY)) ? AW'(idx_inc) : '0;
            end
         end

         ST_RD_DATA: begin
            res_in.ok  = 1'b1;
            res_in.rec = rd_data;
            state_in   = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0,
                               count_ff == CW'(CAPACITY),
                               count_ff == '0,
                               CNT_W'(count_ff),
                               res_ff.rec.price,
                               res_ff.rec.volume,
                               res_ff.rec.name,
                               res_ff.ok};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- tb/sorted_record_list_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_record_list_unit_test
// Drives insert, remove and read words into the sorted record list and checks
// each result word against a software copy of the list kept in a scoreboard.
// A short directed opening covers the edge cases, then random words with
// bursts of growth and shrinkage walk the list between empty and full while
// both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module sorted_record_list_unit_test;
   import srl_pkg::*;

   localparam int LIST_CAP   = 32;
   localparam int NAME_BYTES = 8;

   typedef struct {
      bit          ok;
      logic [63:0] name;
      logic [31:0] volume;
      logic [31:0] price;
      logic [5:0]  count;
      bit          empty;
      bit          full;
   } list_reply;

   class record_list_checker;
      rec_type     ledger[LIST_CAP];
      int unsigned held;
      list_reply   due_replies[$];
      int unsigned mismatches;
      int unsigned inserts, refused, removed, missed, reads_hit, reads_bad;
      int unsigned times_full, times_emptied;

      function new();
         held = 0;
      endfunction

      function logic [63:0] tidy_name(logic [63:0] key, bit fold);
         logic [63:0] res;
         logic [7:0]  b;
         bit          ended;
         res   = '0;
         ended = 0;
         for (int i = 0; i < 8; i++) begin
            b = key[63-8*i -: 8];
            if (i >= NAME_BYTES || b == 8'h00) ended = 1;
            if (ended) b = 8'h00;
            if (fold && b >= 8'h41 && b <= 8'h5a) b = b + 8'h20;
            res[63-8*i -: 8] = b;
         end
         return res;
      endfunction

      function void note_request(op_type op, logic [63:0] key, logic signed [31:0] vol,
                                 logic [31:0] price, logic [5:0] pos);
         list_reply   r;
         logic [63:0] nm;
         int unsigned at;
         r = '{default: '0};
         case (op)
            OP_INSERT: begin
               if (held < LIST_CAP) begin
                  nm = tidy_name(key, 1);
                  at = 0;
                  while (at < held && (ledger[at].name < nm ||
                         (ledger[at].name == nm &&
                          $signed(ledger[at].volume) <= $signed(vol))))
                     at++;
                  for (int i = held; i > at; i--) ledger[i] = ledger[i-1];
                  ledger[at].name   = nm;
                  ledger[at].volume = vol;
                  ledger[at].price  = price;
                  held++;
                  r.ok = 1;
                  inserts++;
                  if (held == LIST_CAP) times_full++;
               end else begin
                  refused++;
               end
            end
            OP_REMOVE: begin
               nm = tidy_name(key, 0);
               at = 0;
               while (at < held && ledger[at].name != nm) at++;
               if (at < held) begin
                  for (int i = at + 1; i < held; i++) ledger[i-1] = ledger[i];
                  held--;
                  r.ok = 1;
                  removed++;
                  if (held == 0) times_emptied++;
               end else begin
                  missed++;
               end
            end
            OP_READ: begin
               if (pos >= 1 && pos <= held) begin
                  r.ok     = 1;
                  r.name   = ledger[pos-1].name;
                  r.volume = ledger[pos-1].volume;
                  r.price  = ledger[pos-1].price;
                  reads_hit++;
               end else begin
                  r.volume = '1;
                  reads_bad++;
               end
            end
            default: ;
         endcase
         r.count = held[5:0];
         r.empty = (held == 0);
         r.full  = (held == LIST_CAP);
         due_replies.push_back(r);
      endfunction

      function void check_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] word);
         list_reply w;
         if (due_replies.size() == 0) begin
            $error("result word %h with nothing awaited", word);
            mismatches++;
            return;
         end
         w = due_replies.pop_front();
         check_field("ok", w.ok, word[0]);
         check_field("out_name", w.name, word[64:1]);
         check_field("out_volume", w.volume, word[96:65]);
         check_field("out_price_bits", w.price, word[128:97]);
         check_field("entry_count", w.count, word[134:129]);
         check_field("is_empty", w.empty, word[135]);
         check_field("is_full", w.full, word[136]);
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   record_list_checker list_check = new();

   string base_names[8] = '{"a", "ab", "abc", "apple", "applepie", "b", "zed", "zz"};

   int send_burst  = 0;
   int ready_hold  = 0;
   int ready_roll;

   sorted_record_list_unit #(
      .CAPACITY  (LIST_CAP),
      .NAME_CHARS(NAME_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("run timed out");
      $display("sorted_record_list_unit_test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) list_check.check_response(rsp_tdata);
      if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 8) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(30, 120);
         end else if (ready_roll < 60) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(0, 2);
         end else if (ready_roll < 92) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(15, 60);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) send_burst = $urandom_range(30, 80);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] key_of(string s);
      logic [63:0] k;
      k = '0;
      for (int i = 0; i < s.len() && i < 8; i++) k[63-8*i -: 8] = s[i];
      return k;
   endfunction

   // fill every byte past the first NUL with non-zero rubbish
   function automatic logic [63:0] add_junk(logic [63:0] key);
      bit ended;
      ended = 0;
      for (int i = 0; i < 8; i++) begin
         if (ended) key[63-8*i -: 8] = 8'($urandom_range(1, 255));
         else if (key[63-8*i -: 8] == 8'h00) ended = 1;
      end
      return key;
   endfunction

   function automatic logic [63:0] mixed_case(logic [63:0] key);
      logic [7:0] b;
      for (int i = 0; i < 8; i++) begin
         b = key[63-8*i -: 8];
         if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1)) key[63-8*i -: 8] = b - 8'h20;
      end
      return key;
   endfunction

   function automatic logic [63:0] odd_bytes();
      logic [7:0]  picks[10] = '{8'h00, 8'h40, 8'h41, 8'h5a, 8'h5b,
                                 8'h60, 8'h61, 8'h7a, 8'h7b, 8'hff};
      logic [63:0] k;
      for (int i = 0; i < 8; i++) k[63-8*i -: 8] = picks[$urandom_range(0, 9)];
      return k;
   endfunction

   function automatic logic [63:0] insert_name();
      int          r;
      logic [63:0] k;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         k = mixed_case(key_of(base_names[$urandom_range(0, 7)]));
         return $urandom_range(0, 1) ? add_junk(k) : k;
      end
      if (r < 9) return {$urandom, $urandom};
      return odd_bytes();
   endfunction

   function automatic logic [63:0] remove_name();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6 && list_check.held > 0)
         return add_junk(list_check.ledger[$urandom_range(0, list_check.held - 1)].name);
      if (r < 8) return mixed_case(key_of(base_names[$urandom_range(0, 7)]));
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] pick_volume();
      logic [31:0] sets[6] = '{32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1,
                               32'h7fff_ffff, 32'h3};
      if ($urandom_range(0, 1)) return sets[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   task automatic send_word(op_type op, logic [63:0] key, logic signed [31:0] vol,
                            logic [31:0] price, logic [5:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {pos, price, vol, key, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      list_check.note_request(op, key, vol, price, pos);
   endtask

   initial begin
      int     growth;
      int     mode_left;
      int     r;
      op_type op;
      logic [5:0] pos;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_READ, '0, 0, '0, 6'd1);
      send_word(OP_REMOVE, key_of("zed"), 0, '0, '0);
      send_word(OP_NONE, '1, -1, '1, 6'd32);
      send_word(OP_INSERT, key_of("ZeTa"), 7, 32'h1234_5678, '0);
      send_word(OP_READ, '0, 0, '0, 6'd1);
      send_word(OP_INSERT, '1, 32'sh7fff_ffff, '1, '0);
      send_word(OP_INSERT, '0, 32'sh8000_0000, '0, '0);
      send_word(OP_INSERT, 64'h4142_0078_797a_4142, 5, 32'h0000_0001, '0);
      send_word(OP_INSERT, key_of("ab"), 5, 32'h0000_0002, '0);
      send_word(OP_INSERT, key_of("aB"), -5, 32'h0000_0003, '0);
      send_word(OP_INSERT, 64'h405b_607b_415a_617a, -1, 32'hdead_beef, '0);
      send_word(OP_READ, '0, 0, '0, 6'd0);
      send_word(OP_READ, '0, 0, '0, 6'd32);
      for (int i = 1; i <= 7; i++) send_word(OP_READ, '0, 0, '0, 6'(i));
      send_word(OP_REMOVE, key_of("ZETA"), 0, '0, '0);
      send_word(OP_REMOVE, key_of("zeta"), 0, '0, '0);
      send_word(OP_REMOVE, 64'h6162_00ff_ee01_0203, 0, '0, '0);
      send_word(OP_READ, '0, 0, '0, 6'd1);
      send_word(OP_READ, '0, 0, '0, 6'd2);

      growth    = 0;
      mode_left = 0;
      for (int n = 0; n < 1800; n++) begin
         if (mode_left == 0) begin
            growth    = $urandom_range(0, 2);
            mode_left = $urandom_range(40, 160);
         end
         mode_left--;
         r = $urandom_range(0, 99);
         case (growth)
            0:       op = op_type'(r < 60 ? OP_INSERT : r < 75 ? OP_REMOVE :
                                   r < 98 ? OP_READ : OP_NONE);
            1:       op = op_type'(r < 20 ? OP_INSERT : r < 70 ? OP_REMOVE :
                                   r < 98 ? OP_READ : OP_NONE);
            default: op = op_type'(r < 40 ? OP_INSERT : r < 70 ? OP_REMOVE :
                                   r < 98 ? OP_READ : OP_NONE);
         endcase
         r = $urandom_range(0, 99);
         if (r < 70 && list_check.held > 0) pos = 6'($urandom_range(1, list_check.held));
         else if (r < 85) pos = '0;
         else pos = 6'($urandom_range(0, 32));
         case (op)
            OP_INSERT: send_word(op, insert_name(), pick_volume(),
                                 $urandom_range(0, 9) == 0 ? '1 : $urandom, pos);
            OP_REMOVE: send_word(op, remove_name(), pick_volume(), $urandom, pos);
            default:   send_word(op, {$urandom, $urandom}, pick_volume(), $urandom, pos);
         endcase
      end

      req_tvalid <= 1'b0;
      while (list_check.due_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d inserts (%0d refused while full), %0d removes (%0d unmatched),",
               list_check.inserts, list_check.refused, list_check.removed, list_check.missed);
      $display("%0d reads in range, %0d out of range; list filled %0d times, emptied %0d times",
               list_check.reads_hit, list_check.reads_bad, list_check.times_full,
               list_check.times_emptied);
      if (list_check.mismatches == 0) begin
         $display("sorted_record_list_unit_test passed");
      end else begin
         $display("sorted_record_list_unit_test failed");
      end
      $finish;
   end

endmodule
